FILE: hdl/timestamp_ordered_request_queue_macros.svh
// Assertion helpers shared by the queue RTL.
`ifndef TIMESTAMP_ORDERED_REQUEST_QUEUE_MACROS_SVH
`define TIMESTAMP_ORDERED_REQUEST_QUEUE_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define TORQ_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define TORQ_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/torq_pkg.sv
package torq_pkg;

  localparam int unsigned TS_W    = 32;
  localparam int unsigned SRC_W   = 8;
  localparam int unsigned ENTRY_W = TS_W + SRC_W;
  localparam int unsigned COUNT_W = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_QUERIED   = 3'd5
  } torq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_HEAD,
    S_HEAD_WAIT
  } torq_state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [TS_W-1:0]  request_ts;
    logic [SRC_W-1:0] request_src;
  } torq_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic               head_valid;
    logic [SRC_W-1:0]   head_src;
    logic [TS_W-1:0]    head_ts;
    logic               self_first;
  } torq_rsp_t;

  // (ta, sa) orders strictly before (tb, sb)
  function automatic logic earlier(input logic [TS_W-1:0] ta, input logic [SRC_W-1:0] sa,
                                   input logic [TS_W-1:0] tb, input logic [SRC_W-1:0] sb);
    logic r;
    if (ta != tb) begin
      r = (ta < tb);
    end else begin
      r = (sa < sb);
    end
    return r;
  endfunction

endpackage

FILE: hdl/timestamp_ordered_request_queue.sv
// Each transaction runs as a sequence of states: a query reads the head only; a remove or a
//   rejected insert scans the queued entries first; an insert scans, then moves the entries
//   from the tail down to the new slot pos up by one, writes the new entry, then reads the head.
// One transaction at a time: a new request is taken only in idle; the entry RAM is swept one entry a cycle.
// Reset (rst, synchronous, active high) empties the queue and sets self_id to 0;
//   RAM contents are not cleared, only entries below the count are ever used.
`include "timestamp_ordered_request_queue_macros.svh"

module timestamp_ordered_request_queue import torq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             req_valid,
  output logic             req_ready,
  input  torq_req_t        req_data,
  // result channel
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output torq_rsp_t        rsp_data,
  // self_id register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SRC_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // control state
  torq_state_t state, state_next;
  logic [CW-1:0] occ, occ_next;          // queued entries
  logic [CW-1:0] rd_idx, rd_idx_next;    // sweep pointer
  logic          pend, pend_next;        // RAM read data valid this cycle
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic          found, found_next;      // source seen during the search
  logic          pos_hit, pos_hit_next;  // insert slot located
  logic [CW-1:0] pos, pos_next;
  logic [SRC_W-1:0] self_id;
  logic          rsp_valid_next;

  // payload
  torq_req_t     req, req_next;
  torq_status_t  status, status_next;
  torq_rsp_t     rsp_next;

  // entry RAM
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TS_W-1:0]    rd_ts;
  logic [SRC_W-1:0]   rd_src;
  logic               issue;
  logic               src_hit;

  torq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ts     = ram_rdata[ENTRY_W-1:SRC_W];
  assign rd_src    = ram_rdata[SRC_W-1:0];
  assign src_hit   = (rd_src == req.request_src);
  assign cfg_ready = 1'b1;

  // Sequencer: sweeps the RAM through one read port and one write port, one
  // entry per cycle, with the registered read data tracked by pend/pend_idx.
  always_comb begin
    state_next     = state;
    occ_next       = occ;
    rd_idx_next    = rd_idx;
    pend_next      = 1'b0;
    pend_idx_next  = pend_idx;
    found_next     = found;
    pos_hit_next   = pos_hit;
    pos_next       = pos;
    req_next       = req;
    status_next    = status;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp_data;
    req_ready      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    issue          = 1'b0;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_next     = req_data;
          rd_idx_next  = '0;
          found_next   = 1'b0;
          pos_hit_next = 1'b0;
          if (req_data.op == OP_INSERT || req_data.op == OP_REMOVE) begin
            state_next = S_SCAN;
          end else begin
            // unused op code behaves as a query
            status_next = ST_QUERIED;
            state_next  = S_HEAD;
          end
        end
      end

      // Search pass: duplicate / victim lookup and insert slot. A remove closes
      // the gap in the same pass by writing each later entry one place down.
      S_SCAN: begin
        issue = (rd_idx < occ);
        if (issue) begin
          ram_raddr     = rd_idx[AW-1:0];
          rd_idx_next   = rd_idx + CW'(1);
          pend_next     = 1'b1;
          pend_idx_next = rd_idx[AW-1:0];
        end
        if (pend) begin
          if (req.op == OP_INSERT) begin
            if (src_hit) begin
              found_next = 1'b1;
            end
            if (!pos_hit && earlier(req.request_ts, req.request_src, rd_ts, rd_src)) begin
              pos_hit_next = 1'b1;
              pos_next     = CW'(pend_idx);
            end
          end else begin
            if (found) begin
              ram_we    = 1'b1;
              ram_waddr = pend_idx - AW'(1);
              ram_wdata = ram_rdata;
            end else if (src_hit) begin
              found_next = 1'b1;
            end
          end
        end
        if (!issue && !pend) begin
          if (req.op == OP_INSERT) begin
            if (found) begin
              status_next = ST_DUPLICATE;
              state_next  = S_HEAD;
            end else if (occ == CW'(QUEUE_DEPTH)) begin
              status_next = ST_FULL;
              state_next  = S_HEAD;
            end else begin
              if (!pos_hit) begin
                pos_next = occ;
              end
              rd_idx_next = occ;
              state_next  = S_SHIFT;
            end
          end else begin
            if (found) begin
              occ_next    = occ - CW'(1);
              status_next = ST_REMOVED;
            end else begin
              status_next = ST_NOT_FOUND;
            end
            state_next = S_HEAD;
          end
        end
      end

      // Open the slot: move entries from the tail down to pos up by one, then write the new entry at pos.
      S_SHIFT: begin
        issue = (rd_idx > pos);
        if (issue) begin
          ram_raddr     = AW'(rd_idx - CW'(1));
          rd_idx_next   = rd_idx - CW'(1);
          pend_next     = 1'b1;
          pend_idx_next = AW'(rd_idx - CW'(1));
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx + AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!issue && !pend) begin
          ram_we      = 1'b1;
          ram_waddr   = AW'(pos);
          ram_wdata   = {req.request_ts, req.request_src};
          occ_next    = occ + CW'(1);
          status_next = ST_INSERTED;
          state_next  = S_HEAD;
        end
      end

      S_HEAD: begin
        // read address 0 is the default; data arrives next cycle
        state_next = S_HEAD_WAIT;
      end

      S_HEAD_WAIT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.status      = status;
          rsp_next.entry_count = COUNT_W'(occ);
          rsp_next.head_valid  = (occ != '0);
          rsp_next.head_src    = (occ != '0) ? rd_src : '0;
          rsp_next.head_ts     = (occ != '0) ? rd_ts : '0;
          rsp_next.self_first  = (occ != '0) && (rd_src == self_id);
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rd_idx    <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      pos_hit   <= 1'b0;
      rsp_valid <= 1'b0;
      self_id   <= '0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      rd_idx    <= rd_idx_next;
      pend      <= pend_next;
      found     <= found_next;
      pos_hit   <= pos_hit_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_valid) begin
        self_id <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    pos      <= pos_next;
    req      <= req_next;
    status   <= status_next;
    rsp_data <= rsp_next;
  end

  `TORQ_ASSERT_IMPL(a_occ_bound, clk, rst, 1'b1, occ <= CW'(QUEUE_DEPTH), "count past depth")
  `TORQ_ASSERT_IMPL(a_wr_in_range, clk, rst, ram_we, CW'(ram_waddr) <= occ, "write beyond tail")
  `TORQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, state != S_IDLE, "accepted but idle")
  `TORQ_ASSERT_IMPL(a_empty_head_zero, clk, rst, rsp_valid && !rsp_data.head_valid, rsp_data.head_ts == '0 && rsp_data.head_src == '0 && !rsp_data.self_first, "empty head not zero")

endmodule

FILE: hdl/torq_ram.sv
module torq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
